### sv/greedy_list_scheduler_macros.svh
// assertion macros shared by the scheduler modules
`ifndef GREEDY_LIST_SCHEDULER_MACROS_SVH
`define GREEDY_LIST_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define GLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication outside reset
`define GLS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define GLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GLS_ASSERT(lbl, clk, rst, prop, msg)
`define GLS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define GLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### sv/gls_pkg.sv
// types and constants of the greedy list scheduler
`default_nettype none

package gls_pkg;

   // processor array size and derived widths
   localparam int MAX_PROCESSORS = 16;
   localparam int IDX_W          = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
   localparam int CNT_W          = $clog2(MAX_PROCESSORS + 1);

   // field widths
   localparam int TIME_W  = 24;
   localparam int LOAD_W  = 40;
   localparam int PIDX_W  = 4;
   localparam int CFG_W   = 5;

   // configuration reset value
   localparam logic [CFG_W-1:0] PROC_COUNT_RESET = CFG_W'(4);

   // saturated load
   localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // one classified task word
   typedef struct packed {
      logic [TIME_W-1:0] task_time;
      logic              first_task;
      logic              last_task;
      logic [CNT_W-1:0]  n_active;
   } gls_item_type;

   // queue status seen by the back end
   typedef struct packed {
      logic empty;
      logic full;
   } gls_qstat_type;

endpackage

`default_nettype wire

### sv/gls_front.sv
// front end: count register, clamping and push into the queue
`default_nettype none

module gls_front
   import gls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CFG_W-1:0]    csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [TIME_W-1:0]   req_task_time,
   input  wire logic                req_first_task,
   input  wire logic                req_last_task,
   input  wire gls_qstat_type       q_stat,
   output logic                     q_push,
   output gls_item_type             q_item
);

   localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

   logic [CFG_W-1:0] proc_count_ff;
   logic [CFG_W-1:0] proc_count_in;
   logic [CMP_W-1:0] count_ext;
   logic [CNT_W-1:0] n_active;

   // processor count register
   always_comb begin
      proc_count_in = proc_count_ff;
      if (csr_write_enable) begin
         proc_count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= PROC_COUNT_RESET;
      end else begin
         proc_count_ff <= proc_count_in;
      end
   end

   // clamp to one .. MAX_PROCESSORS
   always_comb begin
      count_ext = CMP_W'(proc_count_ff);
      if (count_ext == '0) begin
         n_active = CNT_W'(1);
      end else if (count_ext > CMP_W'(MAX_PROCESSORS)) begin
         n_active = CNT_W'(MAX_PROCESSORS);
      end else begin
         n_active = CNT_W'(count_ext);
      end
   end

   // hand the word to the queue
   assign req_stall            = q_stat.full;
   assign q_push               = req_valid && !q_stat.full;
   assign q_item.task_time     = req_task_time;
   assign q_item.first_task    = req_first_task;
   assign q_item.last_task     = req_last_task;
   assign q_item.n_active      = n_active;

endmodule

`default_nettype wire

### sv/gls_queue.sv
// short queue of classified words between front and back
`default_nettype none
`include "greedy_list_scheduler_macros.svh"

module gls_queue
   import gls_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire gls_item_type  push_item,
   input  wire logic          pop,
   output gls_item_type       pop_item,
   output gls_qstat_type      stat
);

   gls_item_type       entry_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item   = entry_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_W'(Q_DEPTH));

   // checks on queue use
   `GLS_ASSERT(a_q_count_range, clock, reset, count_ff <= QCNT_W'(Q_DEPTH), "queue overfilled")
   `GLS_ASSERT_IMPL(a_q_no_push_full, clock, reset, push, !stat.full, "push into full queue")
   `GLS_ASSERT_IMPL(a_q_no_pop_empty, clock, reset, pop, !stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

### sv/gls_back.sv
// back end: least-loaded scan over the load memory, update and result register
`default_nettype none
`include "greedy_list_scheduler_macros.svh"

module gls_back
   import gls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gls_qstat_type       q_stat,
   input  wire gls_item_type        q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [PIDX_W-1:0]        rsp_processor_index,
   output logic [LOAD_W-1:0]        rsp_makespan,
   output logic                     rsp_schedule_done
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   logic [1:0]                state_ff;
   logic [1:0]                state_in;
   gls_item_type              cur_ff;
   logic [CNT_W-1:0]          issue_ff;
   logic [CNT_W-1:0]          issue_in;
   logic                      rd_pend_ff;
   logic                      rd_pend_in;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic [LOAD_W-1:0]         load_rd_ff;
   logic [LOAD_W-1:0]         best_load_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [MAX_PROCESSORS-1:0] load_vld_ff;
   logic [MAX_PROCESSORS-1:0] load_vld_in;
   logic [LOAD_W-1:0]         makespan_ff;
   logic [LOAD_W-1:0]         makespan_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [PIDX_W-1:0]         rsp_index_ff;
   logic [LOAD_W-1:0]         rsp_makespan_ff;
   logic                      rsp_done_ff;
   logic [LOAD_W-1:0]         load_mem [MAX_PROCESSORS];

   logic                      issue_go;
   logic [LOAD_W-1:0]         rd_val;
   logic                      take_rd;
   logic                      scan_last;
   logic                      upd_fire;
   logic [LOAD_W:0]           sum;
   logic [LOAD_W-1:0]         new_load;

   // scan control
   assign issue_go  = (state_ff == S_SCAN) && (issue_ff < cur_ff.n_active);
   assign rd_val    = load_vld_ff[rd_idx_ff] ? load_rd_ff : '0;
   assign take_rd   = rd_pend_ff && ((rd_idx_ff == '0) || (rd_val < best_load_ff));
   assign scan_last = rd_pend_ff && (CNT_W'(rd_idx_ff) + CNT_W'(1) == cur_ff.n_active);
   assign upd_fire  = (state_ff == S_UPD) && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = (state_ff == S_IDLE) && !q_stat.empty;

   // saturating add of the task time to the chosen load
   assign sum      = {1'b0, best_load_ff} + (LOAD_W + 1)'(cur_ff.task_time);
   assign new_load = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];

   // next state and control registers
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      rd_pend_in   = issue_go;
      load_vld_in  = load_vld_ff;
      makespan_in  = makespan_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               issue_in = '0;
               state_in = S_SCAN;
               if (q_item.first_task) begin
                  load_vld_in = '0;
                  makespan_in = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue_go) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (scan_last) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (upd_fire) begin
               load_vld_in[best_idx_ff] = 1'b1;
               if (new_load > makespan_ff) begin
                  makespan_in = new_load;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         load_vld_ff  <= '0;
         makespan_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         load_vld_ff  <= load_vld_in;
         makespan_ff  <= makespan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (issue_go) begin
         rd_idx_ff <= issue_ff[IDX_W-1:0];
      end
      if (take_rd) begin
         best_load_ff <= rd_val;
         best_idx_ff  <= rd_idx_ff;
      end
      if (upd_fire) begin
         rsp_index_ff    <= PIDX_W'(best_idx_ff);
         rsp_makespan_ff <= (new_load > makespan_ff) ? new_load : makespan_ff;
         rsp_done_ff     <= cur_ff.last_task;
      end
   end

   // load memory, one read and one write port
   always_ff @(posedge clock) begin
      if (issue_go) begin
         load_rd_ff <= load_mem[issue_ff[IDX_W-1:0]];
      end
      if (upd_fire) begin
         load_mem[best_idx_ff] <= new_load;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_processor_index = rsp_index_ff;
   assign rsp_makespan        = rsp_makespan_ff;
   assign rsp_schedule_done   = rsp_done_ff;

   // checks on the scan and update
   `GLS_ASSERT_IMPL(a_rd_in_range, clock, reset, rd_pend_ff, CNT_W'(rd_idx_ff) < cur_ff.n_active, "scan read past active processors")
   `GLS_ASSERT_IMPL(a_best_in_range, clock, reset, state_ff == S_UPD, CNT_W'(best_idx_ff) < cur_ff.n_active, "chosen processor out of range")
   `GLS_ASSERT_NEXT(a_makespan_covers, clock, reset, upd_fire, makespan_ff >= $past(new_load), "makespan below updated load")

endmodule

`default_nettype wire

### sv/greedy_list_scheduler.sv
// top level of the greedy least-loaded list scheduler
//
//  port group | dir | handshake        | contents
//  req_       | in  | valid / stall    | task_time, first_task, last_task
//  rsp_       | out | valid / stall    | processor_index, makespan, schedule_done
//  csr_       | in  | write enable     | processor_count
//
// a word passes through the back end in its idle, scan and update steps, scanning the active processors;
// the scan reads one processor load per cycle from the load memory
// a two-word queue lets the front take words while the back end scans
// reset is synchronous and clears loads, makespan and the count to four processors
// first_task clears all loads together through per-processor valid bits
// a stalled result holds the back end in its update step until taken
`default_nettype none

module greedy_list_scheduler
   import gls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CFG_W-1:0]    csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [TIME_W-1:0]   req_task_time,
   input  wire logic                req_first_task,
   input  wire logic                req_last_task,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [PIDX_W-1:0]        rsp_processor_index,
   output logic [LOAD_W-1:0]        rsp_makespan,
   output logic                     rsp_schedule_done
);

   gls_qstat_type q_stat;
   gls_item_type  push_item;
   gls_item_type  pop_item;
   logic          q_push;
   logic          q_pop;

   // front end
   gls_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_task_time    (req_task_time),
      .req_first_task   (req_first_task),
      .req_last_task    (req_last_task),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   // queue between the two halves
   gls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   // back end
   gls_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_stat              (q_stat),
      .q_item              (pop_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_processor_index (rsp_processor_index),
      .rsp_makespan        (rsp_makespan),
      .rsp_schedule_done   (rsp_schedule_done)
   );

endmodule

`default_nettype wire

### verif/greedy_list_scheduler_tb.sv
// self-checking testbench for the greedy least-loaded list scheduler
module greedy_list_scheduler_tb;
   import gls_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // sender pacing and receiver stall styles
   typedef enum int {PACE_STEADY, PACE_BURSTY} pace_mode_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   // one task word as offered on the request side
   typedef struct packed {
      logic [TIME_W-1:0] task_time;
      logic              first_task;
      logic              last_task;
   } task_word_type;

   // one predicted assignment
   typedef struct packed {
      logic [PIDX_W-1:0] processor_index;
      logic [LOAD_W-1:0] makespan;
      logic              schedule_done;
   } assignment_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [CFG_W-1:0]    csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [TIME_W-1:0]   req_task_time = '0;
   logic                req_first_task = 1'b0;
   logic                req_last_task = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PIDX_W-1:0]   rsp_processor_index;
   logic [LOAD_W-1:0]   rsp_makespan;
   logic                rsp_schedule_done;

   // predictor state
   logic [LOAD_W-1:0]   proc_load [MAX_PROCESSORS];
   logic [LOAD_W-1:0]   peak_load;
   logic [CFG_W-1:0]    proc_count_q;

   task_word_type       task_backlog[$];
   assignment_type      expected_assignments[$];
   task_word_type       drive_word;
   assignment_type      want;

   pace_mode_type       pace_mode = PACE_BURSTY;
   stall_mode_type      stall_mode = STALL_RANDOM;
   int unsigned         burst_left = 0;
   int unsigned         gap_left = 0;
   int unsigned         holds_wanted = 0;
   int unsigned         holds_served = 0;
   int unsigned         hold_left = 0;
   int unsigned         stall_tick = 0;
   int unsigned         stall_period = 8;
   int unsigned         stall_duty = 3;
   int unsigned         mismatch_count = 0;
   longint unsigned     cycle_count = 0;

   greedy_list_scheduler u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_task_time       (req_task_time),
      .req_first_task      (req_first_task),
      .req_last_task       (req_last_task),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_processor_index (rsp_processor_index),
      .rsp_makespan        (rsp_makespan),
      .rsp_schedule_done   (rsp_schedule_done)
   );

   // clock generation
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // least-loaded assignment with saturating loads
   function automatic assignment_type assign_least_loaded(input task_word_type w);
      assignment_type  r;
      int unsigned     n;
      int unsigned     best;
      logic [LOAD_W:0] sum;
      if (proc_count_q == 0) begin
         n = 1;
      end else if (proc_count_q > MAX_PROCESSORS) begin
         n = MAX_PROCESSORS;
      end else begin
         n = proc_count_q;
      end
      if (w.first_task) begin
         foreach (proc_load[j]) proc_load[j] = '0;
         peak_load = '0;
      end
      best = 0;
      for (int j = 1; j < n; j++) begin
         if (proc_load[j] < proc_load[best]) best = j;
      end
      sum = {1'b0, proc_load[best]} + (LOAD_W+1)'(w.task_time);
      proc_load[best] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
      if (proc_load[best] > peak_load) peak_load = proc_load[best];
      r.processor_index = PIDX_W'(best);
      r.makespan        = peak_load;
      r.schedule_done   = w.last_task;
      return r;
   endfunction

   // request driver: takes words from the backlog, bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_assignments.push_back(assign_least_loaded(
               '{task_time: req_task_time, first_task: req_first_task,
                 last_task: req_last_task}));
         end
         if (!req_valid || !req_stall) begin
            if (pace_mode == PACE_BURSTY && gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (task_backlog.size() != 0) begin
               drive_word = task_backlog.pop_front();
               req_valid      <= 1'b1;
               req_task_time  <= drive_word.task_time;
               req_first_task <= drive_word.first_task;
               req_last_task  <= drive_word.last_task;
               if (pace_mode == PACE_BURSTY) begin
                  if (burst_left <= 1) begin
                     burst_left <= $urandom_range(1, 8);
                     gap_left   <= $urandom_range(1, 12);
                  end else begin
                     burst_left <= burst_left - 1;
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall: long hold-offs on request, otherwise the current style
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_served != holds_wanted) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_stall    <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               rsp_stall <= (stall_tick < stall_duty);
               if (stall_tick + 1 >= stall_period) begin
                  stall_tick   <= 0;
                  stall_period <= $urandom_range(2, 24);
                  stall_duty   <= $urandom_range(0, 20);
               end else begin
                  stall_tick <= stall_tick + 1;
               end
            end
         endcase
      end
   end

   // result monitor: compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_assignments.size() == 0) begin
            $display("%0t unexpected result: expected none actual idx %0d makespan %0d done %0b",
                     $time, rsp_processor_index, rsp_makespan, rsp_schedule_done);
            mismatch_count++;
         end else begin
            want = expected_assignments.pop_front();
            if (rsp_processor_index !== want.processor_index) begin
               $display("%0t processor_index mismatch: expected %0d actual %0d",
                        $time, want.processor_index, rsp_processor_index);
               mismatch_count++;
            end
            if (rsp_makespan !== want.makespan) begin
               $display("%0t makespan mismatch: expected %0d actual %0d",
                        $time, want.makespan, rsp_makespan);
               mismatch_count++;
            end
            if (rsp_schedule_done !== want.schedule_done) begin
               $display("%0t schedule_done mismatch: expected %0b actual %0b",
                        $time, want.schedule_done, rsp_schedule_done);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL greedy_list_scheduler");
         $finish;
      end
   end

   task automatic queue_task(input logic [TIME_W-1:0] t, input logic f, input logic l);
      task_backlog.push_back('{task_time: t, first_task: f, last_task: l});
   endtask

   // write the processor count while the block is idle
   task automatic write_proc_count(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      proc_count_q = value;
   endtask

   // hold until every word is sent and every result is back
   task automatic wait_drained();
      do @(negedge clock);
      while (task_backlog.size() != 0 || req_valid || expected_assignments.size() != 0);
   endtask

   // task times: zero, max, small values for ties, or anything
   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return TIME_MAX;
         2, 3: return TIME_W'($urandom_range(0, 15));
         default: return TIME_W'($urandom_range(0, TIME_MAX));
      endcase
   endfunction

   // mostly well-formed schedules, some stray words
   task automatic queue_schedules(input int unsigned words);
      int unsigned made;
      int unsigned len;
      made = 0;
      while (made < words) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_task(pick_time(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            made++;
         end else begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
               queue_task(pick_time(), i == 0, i == len - 1);
            end
            made += len;
         end
      end
   endtask

   // stimulus sequence
   initial begin
      logic [CFG_W-1:0] count_value;
      foreach (proc_load[j]) proc_load[j] = '0;
      peak_load    = '0;
      proc_count_q = PROC_COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset count of four, no first task, extreme times
      queue_task('0, 1'b0, 1'b0);
      queue_task(TIME_MAX, 1'b0, 1'b0);
      queue_task(TIME_MAX, 1'b0, 1'b0);
      queue_task(TIME_W'(1), 1'b0, 1'b0);
      queue_task('0, 1'b0, 1'b1);
      wait_drained();

      // count above the maximum, ties on zero loads
      write_proc_count(CFG_W'(31));
      queue_task(TIME_W'(5), 1'b1, 1'b0);
      queue_task('0, 1'b0, 1'b0);
      queue_task('0, 1'b0, 1'b0);
      queue_task(TIME_W'(7), 1'b0, 1'b1);
      wait_drained();

      // shrink the count mid-schedule, peak stays on an unscanned processor
      write_proc_count(CFG_W'(3));
      queue_task(TIME_W'(1), 1'b1, 1'b0);
      queue_task(TIME_W'(1), 1'b0, 1'b0);
      queue_task(TIME_W'(900), 1'b0, 1'b0);
      wait_drained();
      write_proc_count(CFG_W'(2));
      queue_task(TIME_W'(3), 1'b0, 1'b1);
      wait_drained();

      // zero count behaves as one processor
      write_proc_count('0);
      queue_task(TIME_MAX, 1'b1, 1'b0);
      queue_task(TIME_MAX, 1'b0, 1'b1);
      wait_drained();

      write_proc_count(CFG_W'(17));
      queue_task('0, 1'b1, 1'b0);
      queue_task(TIME_W'(2), 1'b0, 1'b1);
      wait_drained();

      // random schedules over a range of counts
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) begin
            count_value = CFG_W'(1);
         end else if (phase == 1) begin
            count_value = CFG_W'(MAX_PROCESSORS);
         end else begin
            count_value = CFG_W'($urandom_range(0, 31));
         end
         write_proc_count(count_value);
         pace_mode  = pace_mode_type'($urandom_range(0, 1));
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         // long receiver hold-off while the sender keeps offering
         if (phase == 4) begin
            pace_mode  = PACE_STEADY;
            stall_mode = STALL_NONE;
            holds_wanted++;
         end
         queue_schedules(80);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS greedy_list_scheduler");
      end else begin
         $display("FAIL greedy_list_scheduler");
      end
      $finish;
   end

endmodule
